// File: src/efd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_pkg: shared types and constants of the escaped frame deframer
// Holds the payload structures, the event and operation codes, the framing
// bytes and the configuration register indexes.
// ----------------------------------------------------------------------------
package efd_pkg;

  // Framing bytes
  localparam logic [7:0] HEAD_BYTE = 8'h3C;
  localparam logic [7:0] END_BYTE  = 8'h3E;
  localparam logic [7:0] ESC_BYTE  = 8'h3F;

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_START    = 3'd1;
  localparam logic [2:0] EV_DATA     = 3'd2;
  localparam logic [2:0] EV_END      = 3'd3;
  localparam logic [2:0] EV_BADESC   = 3'd4;
  localparam logic [2:0] EV_OVERFLOW = 3'd5;
  localparam logic [2:0] EV_TIMEOUT  = 3'd6;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT_TICKS = 1'b0;
  localparam logic CFG_MAX_FRAME_LEN = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [7:0]  MAXLEN_RESET  = 8'd68;

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2
  } mode_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        consumed;
    logic [2:0]  event_res;
    logic [7:0]  data_out;
    logic [7:0]  frame_length;
    logic [15:0] error_count;
  } out_item_t;

  // Status of the result queue as seen by the input stage
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: src/efd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_core: framing state and per-item decode
// Holds the hunt mode, byte count, silence counter and error total, and
// works out one result combinationally from the registered input item.
// ----------------------------------------------------------------------------
module efd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire_i,
  input  efd_pkg::in_item_t  item_i,
  input  logic [15:0]        timeout_ticks_i,
  input  logic [7:0]         max_frame_len_i,
  output efd_pkg::out_item_t res_o
);

  efd_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]     count_r, count_nxt;
  logic [15:0]    idle_r, idle_nxt;
  logic [15:0]    err_r, err_nxt;
  logic [15:0]    idle_inc;
  logic           overflow;
  logic           esc_ok;

  assign idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign overflow = (count_r >= max_frame_len_i);
  assign esc_ok   = (item_i.data_byte == efd_pkg::HEAD_BYTE) ||
                    (item_i.data_byte == efd_pkg::END_BYTE) ||
                    (item_i.data_byte == efd_pkg::ESC_BYTE);

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    idle_nxt  = idle_r;
    err_nxt   = err_r;
    res_o     = '0;

    if (item_i.operation == efd_pkg::OP_TICK) begin
      if (mode_r != efd_pkg::MODE_HUNT) begin
        idle_nxt = idle_inc;
        // A zero timeout compares true at once, which is how one tick behaves.
        if (idle_inc >= timeout_ticks_i) begin
          err_nxt   = err_r + 16'd1;
          mode_nxt  = efd_pkg::MODE_HUNT;
          count_nxt = '0;
          idle_nxt  = '0;
          res_o.event_res = efd_pkg::EV_TIMEOUT;
        end
      end
    end else if (mode_r == efd_pkg::MODE_HUNT) begin
      if (item_i.data_byte == efd_pkg::HEAD_BYTE) begin
        mode_nxt  = efd_pkg::MODE_FRAME;
        count_nxt = '0;
        idle_nxt  = '0;
        res_o.consumed  = 1'b1;
        res_o.event_res = efd_pkg::EV_START;
      end
    end else begin
      res_o.consumed = 1'b1;
      idle_nxt       = '0;
      unique case (mode_r)
        efd_pkg::MODE_FRAME: begin
          if (item_i.data_byte == efd_pkg::END_BYTE) begin
            mode_nxt = efd_pkg::MODE_HUNT;
            res_o.event_res    = efd_pkg::EV_END;
            res_o.frame_length = count_r;
          end else if (item_i.data_byte == efd_pkg::ESC_BYTE) begin
            mode_nxt = efd_pkg::MODE_ESC;
          end else if (item_i.data_byte == efd_pkg::HEAD_BYTE) begin
            count_nxt = '0;
            res_o.event_res = efd_pkg::EV_START;
          end else if (overflow) begin
            err_nxt  = err_r + 16'd1;
            mode_nxt = efd_pkg::MODE_HUNT;
            res_o.event_res = efd_pkg::EV_OVERFLOW;
          end else begin
            count_nxt = count_r + 8'd1;
            res_o.event_res = efd_pkg::EV_DATA;
            res_o.data_out  = item_i.data_byte;
          end
        end
        efd_pkg::MODE_ESC: begin
          if (!esc_ok) begin
            err_nxt  = err_r + 16'd1;
            mode_nxt = efd_pkg::MODE_HUNT;
            res_o.event_res = efd_pkg::EV_BADESC;
          end else if (overflow) begin
            err_nxt  = err_r + 16'd1;
            mode_nxt = efd_pkg::MODE_HUNT;
            res_o.event_res = efd_pkg::EV_OVERFLOW;
          end else begin
            count_nxt = count_r + 8'd1;
            mode_nxt  = efd_pkg::MODE_FRAME;
            res_o.event_res = efd_pkg::EV_DATA;
            res_o.data_out  = item_i.data_byte;
          end
        end
        default: begin
          mode_nxt = efd_pkg::MODE_HUNT;
        end
      endcase
    end
    res_o.error_count = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= efd_pkg::MODE_HUNT;
      count_r <= '0;
      idle_r  <= '0;
      err_r   <= '0;
    end else if (fire_i) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      idle_r  <= idle_nxt;
      err_r   <= err_nxt;
    end
  end

  // A tick never consumes anything.
  a_tick_not_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && (item_i.operation == efd_pkg::OP_TICK) |-> !res_o.consumed)
    else $error("tick item reported as consumed");

  // The error total moves only when an item is processed, and then by at most one.
  a_err_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !fire_i |=> $stable(err_r))
    else $error("error total changed without an item");

  a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i |=> (err_r == $past(err_r)) || (err_r == $past(err_r) + 16'd1))
    else $error("error total moved by more than one");

  // A stray byte while hunting leaves the block hunting.
  a_stray_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && (mode_r == efd_pkg::MODE_HUNT) && (item_i.operation == efd_pkg::OP_BYTE) &&
    (item_i.data_byte != efd_pkg::HEAD_BYTE) |=> (mode_r == efd_pkg::MODE_HUNT))
    else $error("stray byte left the hunting mode");

endmodule

// File: src/efd_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_outq: two-entry result queue
// Registers finished results and holds one spare entry so that the input
// stage can keep working while a result waits on a stalled output.
// ----------------------------------------------------------------------------
module efd_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  efd_pkg::out_item_t push_item_i,
  output efd_pkg::q_status_t status_o,
  output logic               out_valid,
  input  logic               out_stall,
  output efd_pkg::out_item_t out_item
);

  efd_pkg::out_item_t q_r [2];
  logic               rd_ptr_r, rd_ptr_nxt;
  logic               wr_ptr_r, wr_ptr_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = q_r[rd_ptr_r];

  assign status_o.full  = (cnt_r == 2'd2);
  assign status_o.empty = (cnt_r == 2'd0);

  always_comb begin
    rd_ptr_nxt = pop    ? ~rd_ptr_r : rd_ptr_r;
    wr_ptr_nxt = push_i ? ~wr_ptr_r : wr_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      q_r[wr_ptr_r] <= push_item_i;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    status_o.full |-> !push_i)
    else $error("result queue written while full");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    push_i && !pop |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("result queue count lost a push");

  a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
    status_o.empty |-> (rd_ptr_r == wr_ptr_r))
    else $error("result queue pointers differ while empty");

endmodule

// File: src/escaped_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_deframer: byte-stuffed frame decoder
// Strips head, end and escape bytes from a received byte stream, streams
// out frame data and reports frame start, end and framing errors.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------
//  in_     | input     | in_valid/in_stall  | in_item (operation, data_byte)
//  out_    | output    | out_valid/out_stall| out_item (consumed .. error_count)
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
//  One transaction is taken per clock cycle while the output keeps flowing;
//  each result passes through the input register and the result queue.
//  The combinational decode between the input register and the result queue
//  sets the rate; the two-entry result queue keeps out_stall off the in_stall
//  path, so an output stall reaches the input only through the queue registers.
//  rst_n is synchronous and active low; it clears the framing state, the error
//  counter, input register and result queue, and loads register reset values.
//  in_stall depends only on registers, never combinationally on out_stall.
// ----------------------------------------------------------------------------
module escaped_frame_deframer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  efd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output efd_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  // Configuration registers. They must be written only while the block is idle; the block itself does not enforce it.
  logic [15:0] timeout_ticks_r;
  logic [7:0]  max_frame_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= efd_pkg::TIMEOUT_RESET;
      max_frame_len_r <= efd_pkg::MAXLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        efd_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data;
        efd_pkg::CFG_MAX_FRAME_LEN: max_frame_len_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register. The held transaction moves into the decode whenever the
  // result queue has room, so a full queue is the only thing that stalls it.
  logic               in_valid_r, in_valid_nxt;
  efd_pkg::in_item_t  in_item_r;
  efd_pkg::q_status_t q_status;
  efd_pkg::out_item_t core_res;
  logic               advance;
  logic               accept;

  assign advance  = in_valid_r && !q_status.full;
  assign in_stall = in_valid_r && q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_item;
    end
  end

  // Decode and framing state; it advances exactly once per transaction.
  efd_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire_i          (advance),
    .item_i          (in_item_r),
    .timeout_ticks_i (timeout_ticks_r),
    .max_frame_len_i (max_frame_len_r),
    .res_o           (core_res)
  );

  // Result registers with one spare entry between the decode and the output.
  efd_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (advance),
    .push_item_i (core_res),
    .status_o    (q_status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  // Every transaction held in the input register is decoded at most once.
  a_adv_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !accept |=> !in_valid_r)
    else $error("input register kept a transaction that was decoded");

  // Nothing reaches the decode without a held transaction.
  a_adv_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> in_valid_r)
    else $error("decode fired without an input transaction");

  // A new transaction is always taken when the queue has room.
  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !q_status.full |-> !in_stall)
    else $error("input stalled with room in the result queue");

endmodule

// File: tb/escaped_frame_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_deframer_test: self-checking testbench of the frame deframer
// Drives received bytes and timer ticks into the block, predicts every
// result with an independent model of the framing state machine and compares
// each result transaction field by field. Directed tests cover stray bytes,
// escapes, restarts, overflow, silence timeout and back-pressure; random
// frames under varying idling finish the run.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_test;

  // Length of the long receiver hold-off, in clock cycles.
  localparam int unsigned HOLD_CYCLES = 64;
  // Least number of items per random phase that reach the framer (stray bytes and ticks while hunting not counted).
  localparam int unsigned PHASE_ITEMS = 160;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  efd_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  efd_pkg::out_item_t out_item;
  logic               cfg_we = 1'b0;
  logic               cfg_index = efd_pkg::CFG_TIMEOUT_TICKS;
  logic [15:0]        cfg_data = '0;

  escaped_frame_deframer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Framing model. It mirrors the decoder state and is advanced once for
  // every input transaction accepted by the block.
  // --------------------------------------------------------------------------
  efd_pkg::mode_t frame_mode = efd_pkg::MODE_HUNT;
  logic [7:0]     frame_count = '0;
  logic [15:0]    silent_ticks = '0;
  logic [15:0]    error_tally = '0;
  logic [15:0]    timeout_limit = efd_pkg::TIMEOUT_RESET;
  logic [7:0]     max_len = efd_pkg::MAXLEN_RESET;

  // Results predicted for accepted transactions, oldest first.
  efd_pkg::out_item_t pending_results[$];

  int unsigned mismatches = 0;
  int unsigned framer_items = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;

  // An error always sends the decoder back to hunting for a head byte.
  function automatic void count_error();
    error_tally = error_tally + 16'd1;
    frame_mode  = efd_pkg::MODE_HUNT;
  endfunction

  function automatic efd_pkg::out_item_t predict_deframe(input efd_pkg::in_item_t item);
    efd_pkg::out_item_t res;
    logic [7:0] b;
    res = '0;
    b   = item.data_byte;
    if (item.operation == efd_pkg::OP_TICK) begin
      // Ticks only matter inside a frame; the silence count saturates.
      if (frame_mode != efd_pkg::MODE_HUNT) begin
        if (silent_ticks != 16'hFFFF) begin
          silent_ticks = silent_ticks + 16'd1;
        end
        // A limit of zero behaves as one, which this comparison gives anyway.
        if (silent_ticks >= timeout_limit) begin
          count_error();
          frame_count   = '0;
          silent_ticks  = '0;
          res.event_res = efd_pkg::EV_TIMEOUT;
        end
      end
    end else if (frame_mode == efd_pkg::MODE_HUNT) begin
      if (b == efd_pkg::HEAD_BYTE) begin
        frame_mode    = efd_pkg::MODE_FRAME;
        frame_count   = '0;
        silent_ticks  = '0;
        res.consumed  = 1'b1;
        res.event_res = efd_pkg::EV_START;
      end
    end else begin
      res.consumed = 1'b1;
      silent_ticks = '0;
      case (frame_mode)
        efd_pkg::MODE_FRAME: begin
          if (b == efd_pkg::END_BYTE) begin
            frame_mode       = efd_pkg::MODE_HUNT;
            res.event_res    = efd_pkg::EV_END;
            res.frame_length = frame_count;
          end else if (b == efd_pkg::ESC_BYTE) begin
            frame_mode = efd_pkg::MODE_ESC;
          end else if (b == efd_pkg::HEAD_BYTE) begin
            frame_count   = '0;
            res.event_res = efd_pkg::EV_START;
          end else if (frame_count >= max_len) begin
            count_error();
            res.event_res = efd_pkg::EV_OVERFLOW;
          end else begin
            frame_count   = frame_count + 8'd1;
            res.event_res = efd_pkg::EV_DATA;
            res.data_out  = b;
          end
        end
        efd_pkg::MODE_ESC: begin
          if (b != efd_pkg::HEAD_BYTE && b != efd_pkg::END_BYTE &&
              b != efd_pkg::ESC_BYTE) begin
            count_error();
            res.event_res = efd_pkg::EV_BADESC;
          end else if (frame_count >= max_len) begin
            count_error();
            res.event_res = efd_pkg::EV_OVERFLOW;
          end else begin
            frame_count   = frame_count + 8'd1;
            frame_mode    = efd_pkg::MODE_FRAME;
            res.event_res = efd_pkg::EV_DATA;
            res.data_out  = b;
          end
        end
        default: begin
          // The unused mode code simply drops back to hunting.
          frame_mode = efd_pkg::MODE_HUNT;
        end
      endcase
    end
    res.error_count = error_tally;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. Every call starts and ends just after a rising edge. The
  // valid line is left high after a transaction so that back-to-back items
  // need only one assignment per time step; an idle cycle or a drain lowers it.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [7:0] b);
    efd_pkg::in_item_t item;
    item.operation = op;
    item.data_byte = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    // The stall seen here is the value from before the edge.
    do @(posedge clk); while (in_stall);
    // Stray bytes and ticks while hunting do not count as framer traffic.
    if (!(frame_mode == efd_pkg::MODE_HUNT &&
          (op == efd_pkg::OP_TICK || b != efd_pkg::HEAD_BYTE))) begin
      framer_items++;
    end
    pending_results.push_back(predict_deframe(item));
  endtask

  task automatic send_tick();
    send_item(efd_pkg::OP_TICK, 8'($urandom_range(255)));
  endtask

  // Sends one frame data byte, escaping it when it collides with a marker.
  task automatic send_frame_byte(input logic [7:0] b);
    if (b == efd_pkg::HEAD_BYTE || b == efd_pkg::END_BYTE || b == efd_pkg::ESC_BYTE) begin
      send_item(efd_pkg::OP_BYTE, efd_pkg::ESC_BYTE);
    end
    send_item(efd_pkg::OP_BYTE, b);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == efd_pkg::HEAD_BYTE || b == efd_pkg::END_BYTE || b == efd_pkg::ESC_BYTE);
    return b;
  endfunction

  // Stops offering items and waits until every predicted result has been
  // seen, then lets the input register and the result queue settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes are only issued once the block has drained.
  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      efd_pkg::CFG_TIMEOUT_TICKS: timeout_limit = value;
      efd_pkg::CFG_MAX_FRAME_LEN: max_len = value[7:0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold-off on request which is
  // counted down here so the block fills and pushes back on its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : receiver_pacing
    int unsigned hold_left;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Every result transaction is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    efd_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result transaction, expected none, actual %0h",
                 $time, out_item);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("consumed", want.consumed, out_item.consumed);
        check_field("event_res", want.event_res, out_item.event_res);
        check_field("data_out", want.data_out, out_item.data_out);
        check_field("frame_length", want.frame_length, out_item.frame_length);
        check_field("error_count", want.error_count, out_item.error_count);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Stray bytes, all three escapes, a restart, a bad escape and an empty frame,
  // all with the reset register values.
  task automatic test_basic_framing();
    send_item(efd_pkg::OP_BYTE, 8'h00);
    send_item(efd_pkg::OP_BYTE, 8'hFF);
    send_item(efd_pkg::OP_BYTE, efd_pkg::END_BYTE);
    send_item(efd_pkg::OP_BYTE, efd_pkg::ESC_BYTE);
    send_tick();
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    send_item(efd_pkg::OP_BYTE, 8'h00);
    send_item(efd_pkg::OP_BYTE, 8'hFF);
    send_frame_byte(efd_pkg::HEAD_BYTE);
    send_frame_byte(efd_pkg::END_BYTE);
    send_frame_byte(efd_pkg::ESC_BYTE);
    // A head byte in the middle of a frame starts it again from zero.
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    send_item(efd_pkg::OP_BYTE, 8'h5A);
    send_item(efd_pkg::OP_BYTE, efd_pkg::END_BYTE);
    // Escape followed by an ordinary byte is a framing error.
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    send_item(efd_pkg::OP_BYTE, efd_pkg::ESC_BYTE);
    send_item(efd_pkg::OP_BYTE, 8'h41);
    // A tick inside a frame only advances the silence count.
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    send_tick();
    send_item(efd_pkg::OP_BYTE, efd_pkg::END_BYTE);
    drain_results();
  endtask

  // Frames that run past the length limit, at a small, the zero and the largest
  // settings, on both the plain and the escaped data path.
  task automatic test_length_limit();
    write_reg(efd_pkg::CFG_MAX_FRAME_LEN, 16'd4);
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    repeat (5) send_item(efd_pkg::OP_BYTE, plain_byte());
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    repeat (4) send_item(efd_pkg::OP_BYTE, plain_byte());
    send_frame_byte(efd_pkg::END_BYTE);
    drain_results();

    write_reg(efd_pkg::CFG_MAX_FRAME_LEN, 16'd0);
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    send_item(efd_pkg::OP_BYTE, 8'h20);
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    send_item(efd_pkg::OP_BYTE, efd_pkg::END_BYTE);
    drain_results();

    write_reg(efd_pkg::CFG_MAX_FRAME_LEN, 16'd255);
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    repeat (255) send_item(efd_pkg::OP_BYTE, plain_byte());
    send_item(efd_pkg::OP_BYTE, efd_pkg::END_BYTE);
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    repeat (256) send_item(efd_pkg::OP_BYTE, plain_byte());
    drain_results();
    write_reg(efd_pkg::CFG_MAX_FRAME_LEN, {8'd0, efd_pkg::MAXLEN_RESET});
  endtask

  // Silence timeout at limits of one and zero, no timeout under the
  // largest limit, a timeout while an escape is pending and a byte clearing
  // the count.
  task automatic test_silence_timeout();
    write_reg(efd_pkg::CFG_TIMEOUT_TICKS, 16'd1);
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    send_tick();
    drain_results();

    write_reg(efd_pkg::CFG_TIMEOUT_TICKS, 16'd0);
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    send_tick();
    drain_results();

    write_reg(efd_pkg::CFG_TIMEOUT_TICKS, 16'd3);
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    repeat (2) send_tick();
    send_item(efd_pkg::OP_BYTE, plain_byte());
    repeat (3) send_tick();
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    send_item(efd_pkg::OP_BYTE, efd_pkg::ESC_BYTE);
    repeat (3) send_tick();
    drain_results();

    write_reg(efd_pkg::CFG_TIMEOUT_TICKS, 16'hFFFF);
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    repeat (24) send_tick();
    send_item(efd_pkg::OP_BYTE, efd_pkg::END_BYTE);
    drain_results();
    write_reg(efd_pkg::CFG_TIMEOUT_TICKS, efd_pkg::TIMEOUT_RESET);
  endtask

  // The receiver holds off for a long stretch while a frame keeps coming, so
  // the block fills and stalls its input; then the sender pauses until every
  // result is back before sending the rest.
  task automatic test_back_pressure();
    hold_req = 1'b1;
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    repeat (40) send_frame_byte(8'($urandom_range(255)));
    drain_results();
    repeat (10) send_frame_byte(8'($urandom_range(255)));
    send_item(efd_pkg::OP_BYTE, efd_pkg::END_BYTE);
    drain_results();
  endtask

  // Mostly well-formed frames with random content, with now and then a bad
  // escape, a restart, a burst of ticks or an unterminated frame.
  task automatic send_random_frame();
    int unsigned len;
    int unsigned pick;
    send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
    len = ($urandom_range(9) == 0) ? $urandom_range(max_len + 3) : $urandom_range(10);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(efd_pkg::OP_BYTE, efd_pkg::ESC_BYTE);
        send_item(efd_pkg::OP_BYTE, plain_byte());
        return;
      end else if (pick < 7) begin
        repeat ($urandom_range(1, 4)) send_tick();
      end else if (pick < 9) begin
        send_item(efd_pkg::OP_BYTE, efd_pkg::HEAD_BYTE);
      end else if (pick < 24) begin
        case ($urandom_range(2))
          0: send_frame_byte(efd_pkg::HEAD_BYTE);
          1: send_frame_byte(efd_pkg::END_BYTE);
          default: send_frame_byte(efd_pkg::ESC_BYTE);
        endcase
      end else begin
        send_frame_byte(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(19) != 0) begin
      send_item(efd_pkg::OP_BYTE, efd_pkg::END_BYTE);
    end
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = framer_items + PHASE_ITEMS;
    while (framer_items < stop_at) begin
      // Noise between frames: arbitrary bytes and ticks.
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(1) == 0) send_tick();
          else send_item(efd_pkg::OP_BYTE, 8'($urandom_range(255)));
        end
      end
      send_random_frame();
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    write_reg(efd_pkg::CFG_TIMEOUT_TICKS, 16'd2);
    write_reg(efd_pkg::CFG_MAX_FRAME_LEN, 16'd8);
    run_random_phase(16, 83);

    write_reg(efd_pkg::CFG_TIMEOUT_TICKS, 16'd5);
    write_reg(efd_pkg::CFG_MAX_FRAME_LEN, 16'd255);
    run_random_phase(83, 16);

    write_reg(efd_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(1, 6)));
    write_reg(efd_pkg::CFG_MAX_FRAME_LEN, 16'($urandom_range(4, 20)));
    run_random_phase(0, 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_framing();
    test_length_limit();
    test_silence_timeout();
    test_back_pressure();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: the whole run needs well under a quarter of this time.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
